@@ hdl/imu_complementary_attitude_filter_macros.svh @@
// Assertion helpers for the attitude filter
`ifndef IMU_COMPLEMENTARY_ATTITUDE_FILTER_MACROS_SVH
`define IMU_COMPLEMENTARY_ATTITUDE_FILTER_MACROS_SVH

// same-cycle implication
`define ICAF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("attitude filter check failed");

// next-cycle implication
`define ICAF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("attitude filter check failed");

`endif

@@ hdl/icaf_pkg.sv @@
package icaf_pkg;

  localparam int ITER_W = 6;
  localparam int CORD_W = 28;
  localparam int ROUND_HALF = 62500;
  // 125000 = 15625 << 3; the odd factor is taken by reciprocal multiplication
  localparam int DIV_SHIFT = 3;
  localparam logic [63:0] DIV_ODD = 64'd15625;
  localparam int DIV_ODD_BITS = 14;

  localparam logic [1:0] CFG_W_NORMAL = 2'd0;
  localparam logic [1:0] CFG_W_HIGH   = 2'd1;
  localparam logic [1:0] CFG_ACC_LIM  = 2'd2;

  typedef struct packed {
    logic              load;
    logic              dt;
    logic              prod;
    logic              iter;
    logic              blend;
    logic              commit;
    logic [ITER_W-1:0] cnt;
  } cmd_t;

  // arctan(2^-i) in units of 2^-24 rad
  function automatic logic [CORD_W-1:0] atan_tab(input logic [4:0] i);
    logic [CORD_W-1:0] v;
    case (i)
      5'd0:  v = 28'd13176795;
      5'd1:  v = 28'd7778716;
      5'd2:  v = 28'd4110060;
      5'd3:  v = 28'd2086331;
      5'd4:  v = 28'd1047214;
      5'd5:  v = 28'd524117;
      5'd6:  v = 28'd262123;
      5'd7:  v = 28'd131069;
      5'd8:  v = 28'd65536;
      5'd9:  v = 28'd32768;
      5'd10: v = 28'd16384;
      5'd11: v = 28'd8192;
      5'd12: v = 28'd4096;
      5'd13: v = 28'd2048;
      5'd14: v = 28'd1024;
      5'd15: v = 28'd512;
      5'd16: v = 28'd256;
      5'd17: v = 28'd128;
      5'd18: v = 28'd64;
      5'd19: v = 28'd32;
      5'd20: v = 28'd16;
      5'd21: v = 28'd8;
      5'd22: v = 28'd4;
      5'd23: v = 28'd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/imu_complementary_attitude_filter.sv @@
// An input item passes the DT, PROD, ITER, BLEND and FINAL states before its result is valid;
// ITER runs the CORDIC steps or quotient digits, whichever are more; the step quotients
// come from a reciprocal multiply, 16 numerator bits per cycle, beside both CORDIC units.
// Items are taken only in IDLE, one at a time; the next item is taken while a result waits.
// Reset (rst, synchronous): angles, previous time and rates cleared, weights and limit
// back to their default values, no result pending.
module imu_complementary_attitude_filter
  import icaf_pkg::*;
#(
  parameter int CORDIC_STEPS  = 16,
  parameter int INTERVAL_BITS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [63:0]        sample_time,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] rate_x,
  input  logic signed [15:0] rate_y,
  input  logic signed [15:0] rate_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] roll_out,
  output logic signed [15:0] pitch_out,
  output logic signed [31:0] yaw_out,
  output logic               primed,
  output logic               time_fault,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

`include "imu_complementary_attitude_filter_macros.svh"

  localparam int STEPS_EFF = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int DIGITS    = (INTERVAL_BITS + 17 - DIV_SHIFT + 15) / 16;
  localparam int ITER_LAST = ((DIGITS > STEPS_EFF) ? DIGITS : STEPS_EFF) - 1;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  icaf_ctrl #(.ITER_LAST(ITER_LAST)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
  );

  icaf_datapath #(.INTERVAL_BITS(INTERVAL_BITS), .STEPS_EFF(STEPS_EFF)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample_time(sample_time), .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .rate_x(rate_x), .rate_y(rate_y), .rate_z(rate_z),
    .roll_out(roll_out), .pitch_out(pitch_out), .yaw_out(yaw_out),
    .primed(primed), .time_fault(time_fault)
  );

  `ICAF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `ICAF_ASSERT_NOW(a_unprimed_no_fault, out_valid && !primed, !time_fault)
  `ICAF_ASSERT_NOW(a_unprimed_zero, out_valid && !primed,
                   roll_out == 16'sd0 && pitch_out == 16'sd0 && yaw_out == 32'sd0)

endmodule

@@ hdl/icaf_cordic.sv @@
module icaf_cordic
  import icaf_pkg::*;
(
  input  logic                     clk,
  input  logic                     start,
  input  logic                     step,
  input  logic [ITER_W-1:0]        idx,
  input  logic signed [16:0]       y_in,
  input  logic signed [16:0]       x_in,
  output logic signed [15:0]       angle
);

  logic signed [CORD_W-1:0] x, y, z;
  logic                     zero_vec;
  logic signed [CORD_W-1:0] ys, xs, dx, dy, zr;
  logic [4:0]               sh;

  assign ys = CORD_W'(y_in) <<< 8;
  assign xs = CORD_W'(x_in) <<< 8;
  assign sh = idx[4:0];
  assign dx = y >>> sh;
  assign dy = x >>> sh;
  assign zr = z + CORD_W'(1024);

  always_ff @(posedge clk) begin
    if (start) begin
      zero_vec <= (x_in == 17'sd0) && (y_in == 17'sd0);
      // fold the left half plane into the right one
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x <= ys;
          y <= -xs;
          z <= $signed(atan_tab(5'd0) <<< 1);
        end else begin
          x <= -ys;
          y <= xs;
          z <= -$signed(atan_tab(5'd0) <<< 1);
        end
      end else begin
        x <= xs;
        y <= ys;
        z <= '0;
      end
    end else if (step) begin
      if (y >= 0) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + $signed(atan_tab(sh));
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - $signed(atan_tab(sh));
      end
    end
  end

  assign angle = zero_vec ? 16'sd0 : zr[26:11];

endmodule

@@ hdl/icaf_ctrl.sv @@
module icaf_ctrl
  import icaf_pkg::*;
#(
  parameter int ITER_LAST = 36
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DT    = 3'd1;
  localparam logic [2:0] S_PROD  = 3'd2;
  localparam logic [2:0] S_ITER  = 3'd3;
  localparam logic [2:0] S_BLEND = 3'd4;
  localparam logic [2:0] S_FINAL = 3'd5;

  logic [2:0]        state, state_next;
  logic [ITER_W-1:0] cnt;
  logic              commit;

  assign in_ready = (state == S_IDLE);
  assign commit   = (state == S_FINAL) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_DT;
      S_DT:    state_next = S_PROD;
      S_PROD:  state_next = S_ITER;
      S_ITER:  if (cnt == ITER_W'(ITER_LAST)) state_next = S_BLEND;
      S_BLEND: state_next = S_FINAL;
      S_FINAL: if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_ITER) cnt <= cnt + 1'b1;
      else cnt <= '0;
      if (commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    cmd.load   = in_valid && (state == S_IDLE);
    cmd.dt     = (state == S_DT);
    cmd.prod   = (state == S_PROD);
    cmd.iter   = (state == S_ITER);
    cmd.blend  = (state == S_BLEND);
    cmd.commit = commit;
    cmd.cnt    = cnt;
  end

endmodule

@@ hdl/icaf_datapath.sv @@
module icaf_datapath
  import icaf_pkg::*;
#(
  parameter int INTERVAL_BITS = 20,
  parameter int STEPS_EFF     = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [63:0]         sample_time,
  input  logic signed [15:0]  accel_x,
  input  logic signed [15:0]  accel_y,
  input  logic signed [15:0]  accel_z,
  input  logic signed [15:0]  rate_x,
  input  logic signed [15:0]  rate_y,
  input  logic signed [15:0]  rate_z,
  output logic signed [15:0]  roll_out,
  output logic signed [15:0]  pitch_out,
  output logic signed [31:0]  yaw_out,
  output logic                primed,
  output logic                time_fault
);

  localparam int IB      = INTERVAL_BITS;
  localparam int NUM_W   = IB + 17;
  localparam int STEP_W  = IB + 1;
  localparam int PRED_W  = ((STEP_W > 16) ? STEP_W : 16) + 1;
  localparam int YSUM_W  = ((STEP_W > 32) ? STEP_W : 32) + 1;
  localparam int PROD_W  = PRED_W + 18;
  localparam int BL_W    = PROD_W + 1;
  localparam int NQ_W    = NUM_W - DIV_SHIFT;
  localparam int RSH     = NQ_W + DIV_ODD_BITS;
  localparam int RW      = NQ_W + 1;
  localparam int DIGITS  = (NQ_W + 15) / 16;
  localparam int PAD_W   = DIGITS * 16;
  localparam int ACC_W   = RW + 16;
  localparam int QSH     = RSH - 16 * (DIGITS - 1);
  localparam logic [RW-1:0] RECIP = RW'(((64'd1 << RSH) + DIV_ODD - 64'd1) / DIV_ODD);

  logic [15:0] gyro_weight_normal, gyro_weight_high;
  logic [31:0] acc_limit_sq;
  logic signed [15:0] roll_angle, pitch_angle;
  logic signed [31:0] yaw_angle;
  logic [63:0] prev_time;
  logic signed [15:0] prev_rate [3];
  logic have_previous;

  logic [63:0] s_time;
  logic signed [15:0] s_ax, s_ay, s_az, s_rx, s_ry, s_rz;

  logic [IB-1:0] dt;
  logic          fault;
  logic [32:0]   mag2;

  logic [ACC_W-1:0] div_acc [3];
  logic [PAD_W-1:0] div_num [3];
  logic signed [STEP_W-1:0] step [3];

  logic signed [PROD_W-1:0] pg_r, pa_r, pg_p, pa_p;
  logic signed [15:0] acc_r, acc_p;

  // interval
  logic [63:0] diff;
  assign diff = s_time - prev_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_weight_normal <= 16'd52429;
      gyro_weight_high   <= 16'd65208;
      acc_limit_sq       <= 32'd133454616;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_W_NORMAL: gyro_weight_normal <= cfg_data[15:0];
        CFG_W_HIGH:   gyro_weight_high   <= cfg_data[15:0];
        CFG_ACC_LIM:  acc_limit_sq       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_time <= sample_time;
      s_ax <= accel_x; s_ay <= accel_y; s_az <= accel_z;
      s_rx <= rate_x;  s_ry <= rate_y;  s_rz <= rate_z;
    end
    if (cmd.dt) begin
      fault <= (s_time <= prev_time);
      if (s_time <= prev_time) dt <= '0;
      else if (|diff[63:IB]) dt <= '1;
      else dt <= diff[IB-1:0];
      mag2 <= 33'(32'(s_ax * s_ax)) + 33'(32'(s_ay * s_ay)) + 33'(32'(s_az * s_az));
    end
  end

  // step = sign(rate) * round(|rate| * dt / 125000): drop the factor 8 by a shift, then multiply
  // by the reciprocal of 15625, 16 numerator bits per cycle, low digit first
  for (genvar k = 0; k < 3; k++) begin : g_div
    logic [15:0]       r_abs;
    logic [NUM_W-1:0]  num;
    logic [STEP_W-2:0] quo;
    assign r_abs = prev_rate[k][15] ? 16'(-prev_rate[k]) : 16'(prev_rate[k]);
    assign num   = NUM_W'(r_abs * dt) + NUM_W'(ROUND_HALF);
    assign quo   = (STEP_W-1)'(div_acc[k] >> QSH);
    assign step[k] = prev_rate[k][15] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    always_ff @(posedge clk) begin
      if (cmd.prod) begin
        div_acc[k] <= '0;
        div_num[k] <= PAD_W'(num[NUM_W-1:DIV_SHIFT]);
      end else if (cmd.iter && (cmd.cnt < ITER_W'(DIGITS))) begin
        div_acc[k] <= ACC_W'(div_num[k][15:0] * RECIP) + (div_acc[k] >> 16);
        div_num[k] <= div_num[k] >> 16;
      end
    end
  end

  logic cord_step;
  logic signed [16:0] neg_az, neg_ax;
  assign cord_step = cmd.iter && (cmd.cnt < ITER_W'(STEPS_EFF));
  assign neg_az = -17'(s_az);
  assign neg_ax = -17'(s_ax);

  icaf_cordic u_cordic_roll (
    .clk(clk), .start(cmd.prod), .step(cord_step), .idx(cmd.cnt),
    .y_in(17'(s_ay)), .x_in(neg_az), .angle(acc_r)
  );

  icaf_cordic u_cordic_pitch (
    .clk(clk), .start(cmd.prod), .step(cord_step), .idx(cmd.cnt),
    .y_in(neg_ax), .x_in(neg_az), .angle(acc_p)
  );

  // blend products
  logic [15:0] w;
  logic signed [17:0] wg, wa;
  logic signed [PRED_W-1:0] pred_r, pred_p;
  assign w      = (mag2 >= 33'(acc_limit_sq)) ? gyro_weight_high : gyro_weight_normal;
  assign wg     = $signed({2'b00, w});
  assign wa     = 18'sd65536 - wg;
  assign pred_r = PRED_W'(roll_angle) + PRED_W'(step[0]);
  assign pred_p = PRED_W'(pitch_angle) + PRED_W'(step[1]);

  always_ff @(posedge clk) begin
    if (cmd.blend) begin
      pg_r <= PROD_W'(wg * pred_r);
      pa_r <= PROD_W'(wa * acc_r);
      pg_p <= PROD_W'(wg * pred_p);
      pa_p <= PROD_W'(wa * acc_p);
    end
  end

  function automatic logic signed [15:0] sat16(input logic signed [BL_W-1:0] s);
    logic signed [BL_W-17:0] h;
    h = s[BL_W-1:16];
    if (h > (BL_W-16)'(32767)) return 16'sh7fff;
    else if (h < -(BL_W-16)'(32768)) return -16'sh8000;
    else return h[15:0];
  endfunction

  logic signed [BL_W-1:0] sum_r, sum_p;
  logic signed [YSUM_W-1:0] ysum;
  logic signed [15:0] roll_next, pitch_next;
  logic signed [31:0] yaw_next;
  assign sum_r = BL_W'(pg_r) + BL_W'(pa_r) + BL_W'(32768);
  assign sum_p = BL_W'(pg_p) + BL_W'(pa_p) + BL_W'(32768);
  assign ysum  = YSUM_W'(yaw_angle) + YSUM_W'(step[2]);

  always_comb begin
    roll_next  = roll_angle;
    pitch_next = pitch_angle;
    yaw_next   = yaw_angle;
    if (have_previous) begin
      roll_next  = sat16(sum_r);
      pitch_next = sat16(sum_p);
      if (ysum > YSUM_W'(32'sh7fffffff)) yaw_next = 32'sh7fffffff;
      else if (ysum < -YSUM_W'(64'sh80000000)) yaw_next = 32'sh80000000;
      else yaw_next = ysum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_angle    <= '0;
      pitch_angle   <= '0;
      yaw_angle     <= '0;
      prev_time     <= '0;
      prev_rate[0]  <= '0;
      prev_rate[1]  <= '0;
      prev_rate[2]  <= '0;
      have_previous <= 1'b0;
    end else if (cmd.commit) begin
      roll_angle    <= roll_next;
      pitch_angle   <= pitch_next;
      yaw_angle     <= yaw_next;
      prev_time     <= s_time;
      prev_rate[0]  <= s_rx;
      prev_rate[1]  <= s_ry;
      prev_rate[2]  <= s_rz;
      have_previous <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      roll_out   <= roll_next;
      pitch_out  <= pitch_next;
      yaw_out    <= yaw_next;
      primed     <= have_previous;
      time_fault <= have_previous && fault;
    end
  end

endmodule

@@ dv/imu_attitude_checker.sv @@
module imu_attitude_checker
  import icaf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [63:0]        sample_time,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] rate_x,
  input  logic signed [15:0] rate_y,
  input  logic signed [15:0] rate_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] roll_out,
  input  logic signed [15:0] pitch_out,
  input  logic signed [31:0] yaw_out,
  input  logic               primed,
  input  logic               time_fault,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 16;
  localparam int DT_BITS = 20;
  localparam longint ARCTAN[24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };
  localparam longint YAW_MAX = 64'sd2147483647;
  localparam longint YAW_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [31:0] yaw;
    logic               primed;
    logic               fault;
  } attitude_t;

  attitude_t attitude_q[$];

  logic [15:0]        w_normal, w_high;
  logic [31:0]        acc_lim;
  logic signed [15:0] roll_st, pitch_st;
  logic signed [31:0] yaw_st;
  logic [63:0]        last_time;
  logic signed [15:0] last_rx, last_ry, last_rz;
  logic               have_last;

  function automatic longint accel_angle(longint y, longint x);
    longint z, nx, ny, dx, dy;
    int i;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 256;
    y = y * 256;
    if (x < 0) begin
      if (y >= 0) begin
        nx = y; ny = -x; z = 2 * ARCTAN[0];
      end else begin
        nx = -y; ny = x; z = -2 * ARCTAN[0];
      end
      x = nx;
      y = ny;
    end
    for (i = 0; i < STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ARCTAN[i];
      end else begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end
    end
    return (z + 1024) >>> 11;
  endfunction

  // rate * dt / 125000, ties away from zero
  function automatic longint gyro_step(longint rate, longint dt);
    longint mag, q;
    mag = (rate < 0 ? -rate : rate) * dt;
    q = (mag + 62500) / 125000;
    return rate < 0 ? -q : q;
  endfunction

  function automatic longint mix(longint pred, longint acc, longint w);
    longint s;
    s = (w * pred + (65536 - w) * acc + 32768) >>> 16;
    if (s < -32768) s = -32768;
    if (s > 32767) s = 32767;
    return s;
  endfunction

  function automatic attitude_t advance(logic [63:0] t, longint ax, longint ay, longint az);
    attitude_t r;
    longint dt, mag2, w, y;
    r.primed = 0;
    r.fault = 0;
    if (have_last) begin
      r.primed = 1;
      dt = 0;
      if (t > last_time) begin
        if (t - last_time > 64'((1 << DT_BITS) - 1)) dt = (1 << DT_BITS) - 1;
        else dt = longint'(t - last_time);
      end else r.fault = 1;
      mag2 = ax * ax + ay * ay + az * az;
      w = (mag2 >= longint'(acc_lim)) ? longint'(w_high) : longint'(w_normal);
      roll_st = 16'(mix(longint'(roll_st) + gyro_step(last_rx, dt),
                        accel_angle(ay, -az), w));
      pitch_st = 16'(mix(longint'(pitch_st) + gyro_step(last_ry, dt),
                         accel_angle(-ax, -az), w));
      y = longint'(yaw_st) + gyro_step(last_rz, dt);
      if (y > YAW_MAX) y = YAW_MAX;
      if (y < YAW_MIN) y = YAW_MIN;
      yaw_st = 32'(y);
    end
    last_time = t;
    have_last = 1;
    r.roll = roll_st;
    r.pitch = pitch_st;
    r.yaw = yaw_st;
    return r;
  endfunction

  always @(posedge clk) begin
    attitude_t e;
    if (rst) begin
      w_normal = 16'd52429;
      w_high = 16'd65208;
      acc_lim = 32'd133454616;
      roll_st = 0; pitch_st = 0; yaw_st = 0;
      last_time = 0; last_rx = 0; last_ry = 0; last_rz = 0;
      have_last = 0;
      attitude_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_W_NORMAL: w_normal = cfg_data[15:0];
          CFG_W_HIGH:   w_high = cfg_data[15:0];
          CFG_ACC_LIM:  acc_lim = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (attitude_q.size() == 0) begin
          $error("result item with no expectation waiting");
          fail_count <= fail_count + 1;
        end else begin
          e = attitude_q[0];
          attitude_q.delete(0);
          if (roll_out !== e.roll || pitch_out !== e.pitch || yaw_out !== e.yaw ||
              primed !== e.primed || time_fault !== e.fault)
            fail_count <= fail_count + 1;
          if (roll_out !== e.roll)
            $error("roll_out expected %0d actual %0d", e.roll, roll_out);
          if (pitch_out !== e.pitch)
            $error("pitch_out expected %0d actual %0d", e.pitch, pitch_out);
          if (yaw_out !== e.yaw)
            $error("yaw_out expected %0d actual %0d", e.yaw, yaw_out);
          if (primed !== e.primed)
            $error("primed expected %0d actual %0d", e.primed, primed);
          if (time_fault !== e.fault)
            $error("time_fault expected %0d actual %0d", e.fault, time_fault);
        end
      end
      if (in_valid && in_ready) begin
        attitude_q.insert(attitude_q.size(), advance(sample_time, accel_x, accel_y, accel_z));
        last_rx = rate_x;
        last_ry = rate_y;
        last_rz = rate_z;
      end
    end
    pending <= attitude_q.size();
  end

endmodule

@@ dv/tb_imu_complementary_attitude_filter.sv @@
module tb_imu_complementary_attitude_filter
  import icaf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE = 60;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  logic [63:0]        sample_time = 0;
  logic signed [15:0] accel_x = 0, accel_y = 0, accel_z = 0;
  logic signed [15:0] rate_x = 0, rate_y = 0, rate_z = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [15:0] roll_out, pitch_out;
  logic signed [31:0] yaw_out;
  logic               primed, time_fault;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = 0;
  logic [31:0]        cfg_data = 0;
  int                 fail_count, pending;
  int                 cyc = 0, stall = 0;
  logic               calm;
  logic [63:0]        now_us = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  imu_complementary_attitude_filter dut (.*);
  imu_attitude_checker u_checker (.*);

  assign calm = (cyc >= 6000 && cyc < 9000);

  always @(posedge clk) begin
    cyc <= cyc + 1;
    out_ready <= calm || ($urandom_range(0, 99) >= 17);
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall <= 0;
    else
      stall <= stall + 1;
    if (stall >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_sample(logic [63:0] t, logic [15:0] ax, logic [15:0] ay,
                             logic [15:0] az, logic [15:0] rx, logic [15:0] ry,
                             logic [15:0] rz);
    while (!calm && $urandom_range(0, 99) < 17) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    sample_time <= t;
    accel_x <= ax; accel_y <= ay; accel_z <= az;
    rate_x <= rx; rate_y <= ry; rate_z <= rz;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // drop valid and let every outstanding result drain
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd16();
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] near(int center, int spread);
    return 16'(center + $signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  task automatic random_samples(int n);
    int k, r;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        now_us += $urandom_range(1, 6000);
        send_sample(now_us, near(0, 4000), near(0, 4000), near(-10045, 3000),
                    near(0, 6000), near(0, 6000), near(0, 6000));
      end else if (r < 85) begin
        now_us += $urandom_range(1, 3000);
        send_sample(now_us, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
      end else if (r < 92) begin
        now_us = {$urandom, $urandom};
        send_sample(now_us, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
      end else begin
        // repeated or earlier timestamp
        now_us -= $urandom_range(0, 2000);
        send_sample(now_us, near(0, 4000), near(0, 4000), near(-10045, 3000),
                    rnd16(), rnd16(), rnd16());
      end
    end
  endtask

  initial begin
    int k;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // first sample after reset, then extremes and atan2 corner cases
    send_sample(64'd1000, 16'd0, 16'd0, -16'sd10045, 16'sd32767, -16'sd32768, 16'sd32767);
    send_sample(64'd2000, 16'd0, 16'd0, 16'd0, -16'sd32768, 16'sd32767, -16'sd32768);
    send_sample(64'd3000, 16'd0, 16'd0, 16'sd8000, 16'd1000, 16'd1000, 16'd1000);
    send_sample(64'd3000, 16'sd32767, 16'sd32767, 16'sd32767, 16'd0, 16'd0, 16'd0);
    send_sample(64'd2500, -16'sd32768, -16'sd32768, -16'sd32768, 16'd500, 16'd500, 16'd500);
    send_sample(64'd2600, 16'sd5000, 16'd0, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767);
    send_sample(64'd5000000, 16'd0, -16'sd9000, 16'd0, -16'sd32768, -16'sd32768, -16'sd32768);
    send_sample(64'hFFFF_FFFF_FFFF_FFF0, 16'd0, 16'sd9000, 16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 16'd100, 16'd0, 16'sd100, 16'd0, 16'd0, 16'd0);
    send_sample(64'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(64'd1, 16'sd6000, 16'sd6000, -16'sd6000, 16'sd200, -16'sd200, 16'sd200);
    send_sample(64'd2, -16'sd6000, -16'sd6000, 16'sd6000, 16'd0, 16'd0, 16'd0);
    now_us = 64'd10;
    drain();

    write_reg(CFG_W_NORMAL, 32'd0);
    write_reg(CFG_W_HIGH, 32'd65535);
    write_reg(CFG_ACC_LIM, 32'd0);
    write_reg(CFG_SPARE, 32'hFFFF_FFFF);
    random_samples(120);
    drain();

    write_reg(CFG_W_NORMAL, 32'hFFFF_FFFF);
    write_reg(CFG_W_HIGH, 32'h0001_0000);
    write_reg(CFG_ACC_LIM, 32'd3221225472);
    random_samples(120);
    drain();

    write_reg(CFG_W_NORMAL, 32'd52429);
    write_reg(CFG_W_HIGH, 32'd65208);
    write_reg(CFG_ACC_LIM, 32'd133454616);
    random_samples(160);
    drain();

    write_reg(CFG_W_NORMAL, $urandom_range(0, 65535));
    write_reg(CFG_W_HIGH, $urandom_range(0, 65535));
    write_reg(CFG_ACC_LIM, $urandom_range(0, 32'd3221225472));
    random_samples(120);

    // drive yaw hard with maximal rate and a saturated interval
    for (k = 0; k < 60; k++) begin
      now_us += 64'd2000000;
      send_sample(now_us, near(0, 2000), near(0, 2000), near(-10045, 2000),
                  rnd16(), rnd16(), 16'sd32767);
    end
    for (k = 0; k < 8; k++) begin
      now_us += $urandom_range(1, 4000);
      send_sample(now_us, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), -16'sd32768);
    end
    drain();

    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/icaf_pkg.sv
hdl/icaf_cordic.sv
hdl/icaf_ctrl.sv
hdl/icaf_datapath.sv
hdl/imu_complementary_attitude_filter.sv
dv/imu_attitude_checker.sv
dv/tb_imu_complementary_attitude_filter.sv
